// File: rtl/rwl_pkg.sv
// Package: shared constants, codes and transaction types for the reader-writer lock table.
`default_nettype none
package rwl_pkg;

    localparam int NUM_LOCKS = 16;
    localparam int MAX_COUNT = 255;
    localparam int COUNT_W   = $clog2(MAX_COUNT + 1);
    localparam int IDX_W     = 4;
    localparam int ID_W      = 16;
    localparam int WAKE_W    = 8;
    localparam int MEM_DEPTH = 2 ** IDX_W;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_UNLOCK = 2'd2,
        KIND_CLAIM  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_INVALID = 2'd2,
        ST_QUEUED  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic               no_wait;
        logic [IDX_W-1:0]   lock_index;
        logic [ID_W-1:0]    thread_id;
    } rwl_req_t;

    typedef struct packed {
        status_t            status;
        logic               wake_writer;
        logic [WAKE_W-1:0]  wake_reader_count;
    } rwl_rsp_t;

    typedef struct packed {
        logic [COUNT_W-1:0] reader_count;
        logic [COUNT_W-1:0] waiting_reader_count;
        logic [COUNT_W-1:0] waiting_writer_count;
        logic               writer_held;
        logic [ID_W-1:0]    writer_owner_id;
    } rwl_entry_t;

endpackage
`default_nettype wire

// File: rtl/rwl_update.sv
// Module: next-state and response logic for one lock entry and one request.
`default_nettype none
module rwl_update (
    input  wire rwl_pkg::rwl_req_t   req,
    input  wire rwl_pkg::rwl_entry_t entry_in,
    output rwl_pkg::rwl_entry_t entry_out,
    output logic                write_en,
    output rwl_pkg::rwl_rsp_t   rsp
);
    import rwl_pkg::*;

    rwl_entry_t         e;
    status_t            st;
    logic               wake_w;
    logic [COUNT_W-1:0] n;
    logic [WAKE_W-1:0]  wake_r;

    always_comb begin
        e      = entry_in;
        st     = ST_OK;
        wake_w = 1'b0;
        wake_r = '0;
        n      = '0;
        write_en = 1'b0;

        if (32'(req.lock_index) >= NUM_LOCKS) begin
            st = ST_INVALID;
        end else begin
            write_en = 1'b1;
            case (req.kind)
                KIND_READ: begin
                    if (!e.writer_held && e.waiting_writer_count == '0) begin
                        if (32'(e.reader_count) >= MAX_COUNT) begin
                            st = ST_BUSY;
                        end else begin
                            e.reader_count = e.reader_count + 1'b1;
                        end
                    end else if (req.no_wait) begin
                        st = ST_BUSY;
                    end else if (32'(e.waiting_reader_count) >= MAX_COUNT) begin
                        st = ST_BUSY;
                    end else begin
                        e.waiting_reader_count = e.waiting_reader_count + 1'b1;
                        st = ST_QUEUED;
                    end
                end
                KIND_WRITE: begin
                    if (!e.writer_held && e.reader_count == '0) begin
                        e.writer_held     = 1'b1;
                        e.writer_owner_id = req.thread_id;
                    end else if (req.no_wait) begin
                        st = ST_BUSY;
                    end else if (32'(e.waiting_writer_count) >= MAX_COUNT) begin
                        st = ST_BUSY;
                    end else begin
                        e.waiting_writer_count = e.waiting_writer_count + 1'b1;
                        st = ST_QUEUED;
                    end
                end
                KIND_UNLOCK: begin
                    if (e.writer_held) begin
                        if (e.writer_owner_id != req.thread_id) begin
                            st = ST_INVALID;
                        end else begin
                            e.writer_held     = 1'b0;
                            e.writer_owner_id = '0;
                        end
                    end else if (e.reader_count != '0) begin
                        e.reader_count = e.reader_count - 1'b1;
                    end else begin
                        st = ST_INVALID;
                    end
                    // Hand a freed lock to one writer first, else to every waiting reader.
                    if (st == ST_OK && !e.writer_held && e.reader_count == '0) begin
                        if (e.waiting_writer_count != '0) begin
                            e.waiting_writer_count = e.waiting_writer_count - 1'b1;
                            e.writer_held     = 1'b1;
                            e.writer_owner_id = '0;
                            wake_w = 1'b1;
                        end else if (e.waiting_reader_count != '0) begin
                            n = e.waiting_reader_count;
                            e.reader_count = n;
                            e.waiting_reader_count = '0;
                            wake_r = (32'(n) > 255) ? '1 : WAKE_W'(n);
                        end
                    end
                end
                KIND_CLAIM: begin
                    if (e.writer_held && e.writer_owner_id == '0) begin
                        e.writer_owner_id = req.thread_id;
                    end else begin
                        st = ST_INVALID;
                    end
                end
                default: begin
                    st = ST_INVALID;
                end
            endcase
        end

        entry_out             = e;
        rsp.status            = st;
        rsp.wake_writer       = wake_w;
        rsp.wake_reader_count = wake_r;
    end

endmodule
`default_nettype wire

// File: rtl/reader_writer_lock_manager.sv
// Module: top level of the writer-preferring reader-writer lock table.
// A table of 16 writer-preferring reader-writer locks, all free after reset. Each
// request transaction (read lock, write lock, unlock, or claim by a woken writer)
// returns exactly one result transaction, in order. The block sustains one request
// per cycle while results are taken, also back to back on the same lock. A request
// is accepted into the update stage, and its result is registered in the output
// register, from which it can be taken. This pipeline follows the lock table memory:
// the entry is read into a register when the request is accepted, updated in the
// update stage and written back as that stage advances, and a write that lands in
// the same cycle as the read of the same entry is forwarded into the following
// update. Per-entry valid flops make every entry read as free after reset, so no
// clearing pass is needed. A result waiting in the output register stalls the
// update stage while it is not being taken, and intake stops once the update
// stage also holds a request, so the block holds at most two requests.
`default_nettype none
module reader_writer_lock_manager (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire rwl_pkg::rwl_req_t s_payload,
    output logic               m_valid,
    input  wire                m_ready,
    output rwl_pkg::rwl_rsp_t  m_payload
);
    import rwl_pkg::*;

    // Lock table storage.
    rwl_entry_t             mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]   written_reg;

    // Update stage.
    logic                   s1_valid_reg;
    rwl_req_t               s1_req_reg;
    rwl_entry_t             rd_data_reg;
    logic                   rd_written_reg;
    logic                   bypass_hit_reg;
    rwl_entry_t             bypass_data_reg;

    // Output register.
    logic                   m_valid_reg;
    rwl_rsp_t               m_payload_reg;

    logic                   s_accept;
    logic                   s1_advance;
    logic                   mem_we;
    logic                   upd_we;
    rwl_entry_t             entry_cur;
    rwl_entry_t             entry_next;
    rwl_rsp_t               upd_rsp;

    // Advance the update stage whenever the output register is empty or draining.
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;
    assign mem_we     = s1_advance && upd_we;

    // Pick the freshest copy of the entry: forwarded write, stored data, or reset value.
    always_comb begin
        if (bypass_hit_reg) begin
            entry_cur = bypass_data_reg;
        end else if (rd_written_reg) begin
            entry_cur = rd_data_reg;
        end else begin
            entry_cur = '0;
        end
    end

    rwl_update u_update (
        .req       (s1_req_reg),
        .entry_in  (entry_cur),
        .entry_out (entry_next),
        .write_en  (upd_we),
        .rsp       (upd_rsp)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            bypass_hit_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (mem_we) begin
                written_reg[s1_req_reg.lock_index] <= 1'b1;
            end

            if (s_accept) begin
                rd_written_reg <= written_reg[s_payload.lock_index];
                bypass_hit_reg <= mem_we && (s1_req_reg.lock_index == s_payload.lock_index);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_req_reg      <= s_payload;
            bypass_data_reg <= entry_next;
        end
        if (s1_advance) begin
            m_payload_reg <= upd_rsp;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[s1_req_reg.lock_index] <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= mem[s_payload.lock_index];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
`default_nettype wire

// File: rtl/rwl_checker.sv
// Checker: port-level properties of the lock table, bound to the top level.
`default_nettype none
module rwl_checker (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_valid,
    input wire                s_ready,
    input wire rwl_pkg::rwl_req_t  s_payload,
    input wire                m_valid,
    input wire                m_ready,
    input wire rwl_pkg::rwl_rsp_t  m_payload
);
    import rwl_pkg::*;

    // Drop any pending result during reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

    // Report wakeups only for a completed unlock.
    a_wake_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.wake_writer || m_payload.wake_reader_count != '0)
            |-> m_payload.status == ST_OK)
        else $error("wakeup reported with failing status");

    // Hand the lock to writers or readers, never both.
    a_wake_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.wake_writer |-> m_payload.wake_reader_count == '0)
        else $error("writer and readers woken together");

endmodule

bind reader_writer_lock_manager rwl_checker u_rwl_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
`default_nettype wire

// File: tb/sv/tb_reader_writer_lock_manager.sv
// Testbench for the reader-writer lock table: directed and random requests checked by a predictor.
`timescale 1ns / 100ps
module tb_reader_writer_lock_manager;
    import rwl_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 6;
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOT_LOCKS      = 4;
    localparam int READER_LOCK    = 5;   // lock used for the reader-side limit tests
    localparam int WRITER_LOCK    = 6;   // lock used for the writer-queue limit test
    localparam int DIR_ROWS       = 23;

    // Two copies of the lock table: one advanced when a request is chosen,
    // one advanced when the block accepts it.
    localparam int PLAN_VIEW  = 0;
    localparam int CHECK_VIEW = 1;

    typedef struct {
        bit [COUNT_W-1:0] readers;
        bit [COUNT_W-1:0] rd_waiting;
        bit [COUNT_W-1:0] wr_waiting;
        bit               writer_held;
        bit [ID_W-1:0]    owner;
    } lock_state_t;

    typedef struct {
        bit       pinned;
        rwl_rsp_t rsp;
    } pinned_rsp_t;

    typedef struct {
        kind_t             kind;
        bit                no_wait;
        bit [IDX_W-1:0]    lock;
        bit [ID_W-1:0]     tid;
        bit                pinned;
        status_t           status;
        bit                wake_w;
        bit [WAKE_W-1:0]   wake_r;
    } dir_row_t;

    typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_PULSED} rx_mode_t;

    logic     aclk;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    rwl_req_t s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    rwl_rsp_t m_payload;

    lock_state_t lock_tbl [2][NUM_LOCKS];
    pinned_rsp_t pin_q [$];
    rwl_rsp_t    pending_rsp_q [$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;
    int          burst_left   = 0;
    bit          hold_req     = 1'b0;

    // Directed requests. Rows with pinned = 1 carry a result that is obvious from
    // the state: right after reset, refusals and error codes. The rest go to the
    // predictor.
    dir_row_t directed_rows [DIR_ROWS] = '{
        // free lock after reset: a reader enters
        '{KIND_READ,   1'b0, 4'd0,  16'h0001, 1'b1, ST_OK,      1'b0, 8'd0},
        // try write against a reader
        '{KIND_WRITE,  1'b1, 4'd0,  16'hFFFF, 1'b1, ST_BUSY,    1'b0, 8'd0},
        '{KIND_WRITE,  1'b0, 4'd0,  16'hFFFF, 1'b0, ST_OK,      1'b0, 8'd0},
        // writer waits, so a try read is refused and a plain read queues
        '{KIND_READ,   1'b1, 4'd0,  16'h0002, 1'b1, ST_BUSY,    1'b0, 8'd0},
        '{KIND_READ,   1'b0, 4'd0,  16'h0003, 1'b0, ST_OK,      1'b0, 8'd0},
        // claim before any handover
        '{KIND_CLAIM,  1'b0, 4'd0,  16'hFFFF, 1'b1, ST_INVALID, 1'b0, 8'd0},
        // last reader leaves: the waiting writer is woken
        '{KIND_UNLOCK, 1'b0, 4'd0,  16'h0001, 1'b0, ST_OK,      1'b0, 8'd0},
        // unclaimed lock released by a nonzero thread
        '{KIND_UNLOCK, 1'b0, 4'd0,  16'h1234, 1'b1, ST_INVALID, 1'b0, 8'd0},
        '{KIND_CLAIM,  1'b0, 4'd0,  16'hFFFF, 1'b0, ST_OK,      1'b0, 8'd0},
        // second claim, then an unlock by a thread that does not own it
        '{KIND_CLAIM,  1'b1, 4'd0,  16'hFFFF, 1'b1, ST_INVALID, 1'b0, 8'd0},
        '{KIND_UNLOCK, 1'b0, 4'd0,  16'h0001, 1'b1, ST_INVALID, 1'b0, 8'd0},
        // owner leaves: the waiting reader enters
        '{KIND_UNLOCK, 1'b0, 4'd0,  16'hFFFF, 1'b0, ST_OK,      1'b0, 8'd0},
        '{KIND_UNLOCK, 1'b0, 4'd0,  16'h5555, 1'b0, ST_OK,      1'b0, 8'd0},
        // unlock of a free lock
        '{KIND_UNLOCK, 1'b0, 4'd0,  16'h5555, 1'b1, ST_INVALID, 1'b0, 8'd0},
        '{KIND_WRITE,  1'b1, 4'd15, 16'h8000, 1'b0, ST_OK,      1'b0, 8'd0},
        '{KIND_READ,   1'b0, 4'd15, 16'h7FFF, 1'b0, ST_OK,      1'b0, 8'd0},
        '{KIND_WRITE,  1'b0, 4'd15, 16'hAAAA, 1'b0, ST_OK,      1'b0, 8'd0},
        '{KIND_UNLOCK, 1'b0, 4'd15, 16'h8000, 1'b0, ST_OK,      1'b0, 8'd0},
        // thread zero releases the handed-over, still unclaimed lock
        '{KIND_UNLOCK, 1'b0, 4'd15, 16'h0000, 1'b0, ST_OK,      1'b0, 8'd0},
        // try flag on unlock and claim has no effect
        '{KIND_UNLOCK, 1'b1, 4'd15, 16'h0000, 1'b0, ST_OK,      1'b0, 8'd0},
        '{KIND_CLAIM,  1'b1, 4'd15, 16'h0001, 1'b1, ST_INVALID, 1'b0, 8'd0},
        '{KIND_READ,   1'b1, 4'd15, 16'hFFFF, 1'b0, ST_OK,      1'b0, 8'd0},
        '{KIND_UNLOCK, 1'b0, 4'd15, 16'hFFFF, 1'b0, ST_OK,      1'b0, 8'd0}
    };

    reader_writer_lock_manager dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Advance one view of the lock table by one request and return the result
    // that the request earns.
    function automatic rwl_rsp_t apply_request(input int view, input rwl_req_t r);
        rwl_rsp_t    rsp;
        lock_state_t e;
        int          li;
        rsp = '0;
        rsp.status = ST_OK;
        li = int'(r.lock_index);
        if (li >= NUM_LOCKS) begin
            rsp.status = ST_INVALID;
            return rsp;
        end
        e = lock_tbl[view][li];
        case (r.kind)
            KIND_READ: begin
                if (!e.writer_held && e.wr_waiting == 0) begin
                    if (e.readers >= MAX_COUNT) rsp.status = ST_BUSY;
                    else e.readers = e.readers + 1'b1;
                end else if (r.no_wait) begin
                    rsp.status = ST_BUSY;
                end else if (e.rd_waiting >= MAX_COUNT) begin
                    rsp.status = ST_BUSY;
                end else begin
                    e.rd_waiting = e.rd_waiting + 1'b1;
                    rsp.status = ST_QUEUED;
                end
            end
            KIND_WRITE: begin
                if (!e.writer_held && e.readers == 0) begin
                    e.writer_held = 1'b1;
                    e.owner = r.thread_id;
                end else if (r.no_wait) begin
                    rsp.status = ST_BUSY;
                end else if (e.wr_waiting >= MAX_COUNT) begin
                    rsp.status = ST_BUSY;
                end else begin
                    e.wr_waiting = e.wr_waiting + 1'b1;
                    rsp.status = ST_QUEUED;
                end
            end
            KIND_UNLOCK: begin
                if (e.writer_held) begin
                    if (e.owner != r.thread_id) begin
                        rsp.status = ST_INVALID;
                    end else begin
                        e.writer_held = 1'b0;
                        e.owner = '0;
                    end
                end else if (e.readers != 0) begin
                    e.readers = e.readers - 1'b1;
                end else begin
                    rsp.status = ST_INVALID;
                end
                // hand a freed lock to one writer first, else to every waiting reader
                if (rsp.status == ST_OK && !e.writer_held && e.readers == 0) begin
                    if (e.wr_waiting != 0) begin
                        e.wr_waiting = e.wr_waiting - 1'b1;
                        e.writer_held = 1'b1;
                        e.owner = '0;
                        rsp.wake_writer = 1'b1;
                    end else if (e.rd_waiting != 0) begin
                        rsp.wake_reader_count = (int'(e.rd_waiting) > 255) ?
                            {WAKE_W{1'b1}} : WAKE_W'(e.rd_waiting);
                        e.readers = e.rd_waiting;
                        e.rd_waiting = '0;
                    end
                end
            end
            default: begin
                if (e.writer_held && e.owner == 0) e.owner = r.thread_id;
                else rsp.status = ST_INVALID;
            end
        endcase
        lock_tbl[view][li] = e;
        return rsp;
    endfunction

    function automatic rwl_req_t make_req(input kind_t k, input bit t, input int li,
                                          input bit [ID_W-1:0] tid);
        rwl_req_t r;
        r.kind = k;
        r.no_wait = t;
        r.lock_index = IDX_W'(li);
        r.thread_id = tid;
        return r;
    endfunction

    // Choose a random request, mostly one that makes sense for the planned state
    // of the lock: claim a handover, release an owned lock, let readers leave.
    function automatic rwl_req_t pick_request();
        rwl_req_t    r;
        lock_state_t e;
        int unsigned roll;
        r.kind = kind_t'($urandom_range(0, 3));
        r.no_wait = 1'($urandom);
        r.thread_id = ID_W'($urandom);
        if ($urandom_range(0, 3) == 0) r.lock_index = IDX_W'($urandom);
        else r.lock_index = IDX_W'($urandom_range(0, HOT_LOCKS - 1));
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            // noise: any field value, thread zero now and then
            if ($urandom_range(0, 7) == 0) r.thread_id = '0;
            return r;
        end
        e = lock_tbl[PLAN_VIEW][r.lock_index];
        if (e.writer_held && e.owner == 0 && roll < 75) begin
            r.kind = KIND_CLAIM;
        end else if (e.writer_held && e.owner != 0 && roll < 60) begin
            r.kind = KIND_UNLOCK;
            r.thread_id = e.owner;
        end else if (e.readers != 0 && roll < 55) begin
            r.kind = KIND_UNLOCK;
        end else begin
            r.kind = roll[0] ? KIND_READ : KIND_WRITE;
        end
        return r;
    endfunction

    // Offer one request transaction. Bursts of back-to-back requests alternate
    // with random gaps; valid holds with a stable payload until the handshake.
    task automatic issue(input rwl_req_t r, input bit pinned, input rwl_rsp_t rsp);
        pinned_rsp_t p;
        int          gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        void'(apply_request(PLAN_VIEW, r));
        p.pinned = pinned;
        p.rsp = rsp;
        pin_q.push_back(p);
        s_valid <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold until every expected result has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_rsp_q.size() != 0);
        @(posedge aclk);
    endtask

    // Result side: stall on a pattern whose mode is redrawn at random from time to time,
    // and on request hold off for a long stretch so that the block backs up.
    initial begin : result_sink
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_HALF:   m_ready <= 1'($urandom);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
                    default:   m_ready <= (mode_left % 4 != 0);
                endcase
            end
        end
    end

    // Predict each accepted request and check each accepted result against the
    // oldest expectation. Count cycles with no transaction on either side.
    always @(posedge aclk) begin : scoreboard
        rwl_rsp_t    predicted;
        rwl_rsp_t    want;
        pinned_rsp_t p;
        bit          moved;
        if (aresetn) begin
            moved = 1'b0;
            if (s_valid && s_ready) begin
                moved = 1'b1;
                predicted = apply_request(CHECK_VIEW, s_payload);
                p = pin_q.pop_front();
                pending_rsp_q.push_back(p.pinned ? p.rsp : predicted);
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (pending_rsp_q.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected result: status %0d wake_writer %0d readers_woken %0d",
                                 m_payload.status, m_payload.wake_writer,
                                 m_payload.wake_reader_count);
                    mismatches++;
                end else begin
                    want = pending_rsp_q.pop_front();
                    if (m_payload.status !== want.status ||
                        m_payload.wake_writer !== want.wake_writer ||
                        m_payload.wake_reader_count !== want.wake_reader_count) begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"result %0d mismatch: expected status %0d wake_writer %0d",
                                      " readers_woken %0d, got status %0d wake_writer %0d",
                                      " readers_woken %0d"},
                                     results_seen, want.status, want.wake_writer,
                                     want.wake_reader_count, m_payload.status,
                                     m_payload.wake_writer, m_payload.wake_reader_count);
                        mismatches++;
                    end
                    results_seen++;
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Stop a run that has stopped moving.
    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int       n;
        rwl_req_t r;
        rwl_rsp_t pin;
        bit [ID_W-1:0] tid;

        foreach (lock_tbl[v, i]) lock_tbl[v][i] = '{default: '0};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table.
        foreach (directed_rows[i]) begin
            r = make_req(directed_rows[i].kind, directed_rows[i].no_wait,
                         directed_rows[i].lock, directed_rows[i].tid);
            pin.status = directed_rows[i].status;
            pin.wake_writer = directed_rows[i].wake_w;
            pin.wake_reader_count = directed_rows[i].wake_r;
            issue(r, directed_rows[i].pinned, pin);
        end
        drain();

        // Reader side at its limits: fill the reader count, refuse one more,
        // queue a writer, fill the waiting readers, refuse one more.
        pin = '0;
        pin.status = ST_BUSY;
        for (n = 0; n < MAX_COUNT; n++)
            issue(make_req(KIND_READ, 1'($urandom), READER_LOCK, ID_W'($urandom)), 1'b0, '0);
        issue(make_req(KIND_READ, 1'($urandom), READER_LOCK, ID_W'($urandom)), 1'b1, pin);
        issue(make_req(KIND_WRITE, 1'b0, READER_LOCK, ID_W'($urandom)), 1'b0, '0);
        for (n = 0; n < MAX_COUNT; n++)
            issue(make_req(KIND_READ, 1'b0, READER_LOCK, ID_W'($urandom)), 1'b0, '0);
        issue(make_req(KIND_READ, 1'b0, READER_LOCK, ID_W'($urandom)), 1'b1, pin);
        // Let every reader leave; the last one wakes the writer, whose release
        // then wakes the full count of waiting readers.
        for (n = 0; n < MAX_COUNT; n++)
            issue(make_req(KIND_UNLOCK, 1'($urandom), READER_LOCK, ID_W'($urandom)),
                  1'b0, '0);
        tid = ID_W'($urandom_range(1, 65535));
        issue(make_req(KIND_CLAIM, 1'b0, READER_LOCK, tid), 1'b0, '0);
        pin.status = ST_OK;
        pin.wake_reader_count = {WAKE_W{1'b1}};
        issue(make_req(KIND_UNLOCK, 1'b0, READER_LOCK, tid), 1'b1, pin);

        // Writer queue at its limit.
        issue(make_req(KIND_WRITE, 1'b0, WRITER_LOCK, ID_W'($urandom)), 1'b0, '0);
        for (n = 0; n < MAX_COUNT; n++)
            issue(make_req(KIND_WRITE, 1'b0, WRITER_LOCK, ID_W'($urandom)), 1'b0, '0);
        pin = '0;
        pin.status = ST_BUSY;
        issue(make_req(KIND_WRITE, 1'b0, WRITER_LOCK, ID_W'($urandom)), 1'b1, pin);
        drain();

        // Random traffic, first with the ordinary result-side pattern.
        repeat (RANDOM_ITEMS) issue(pick_request(), 1'b0, '0);
        drain();

        // Random traffic again while the result side holds off for a long
        // stretch, so the block fills up and stalls its input.
        hold_req = 1'b1;
        repeat (RANDOM_ITEMS) issue(pick_request(), 1'b0, '0);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
